// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/blp_pkg.sv =====
package blp_pkg;

  // parse phase, one-hot
  typedef enum logic [4:0] {
    PH_BEGIN  = 5'b00001,
    PH_SFIRST = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_BAD    = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    RF_DEC = 2'd0,
    RF_HEX = 2'd1,
    RF_BIN = 2'd2
  } radix_e;

  typedef enum logic [2:0] {
    STS_OK     = 3'd0,
    STS_HEX    = 3'd1,
    STS_BIN    = 3'd2,
    STS_NUMBER = 3'd3,
    STS_OCTAL  = 3'd4,
    STS_SIGNED = 3'd5,
    STS_RANGE  = 3'd6
  } status_e;

  typedef struct packed {
    phase_e     phase;
    logic       is_negative;
    radix_e     radix_form;
    logic [3:0] digit_count;
    logic [8:0] accumulator;
    status_e    pending_error;
    logic       leading_zero;
  } blp_state_t;

  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       last;
  } blp_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    status_e    status;
  } blp_result_t;

  localparam blp_state_t StateReset = '{
    phase:         PH_BEGIN,
    is_negative:   1'b0,
    radix_form:    RF_DEC,
    digit_count:   4'd0,
    accumulator:   9'd0,
    pending_error: STS_OK,
    leading_zero:  1'b0
  };

  // ascii codes
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChOne     = 8'h31;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperB  = 8'h42;
  localparam logic [7:0] ChUpperF  = 8'h46;
  localparam logic [7:0] ChUpperX  = 8'h58;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] CaseShift = 8'd32;

  localparam logic [8:0] AccMax       = 9'd511;
  localparam logic [8:0] NegMagMax    = 9'd128;
  localparam logic [8:0] ByteMax      = 9'd255;
  localparam logic [3:0] HexMaxDigits = 4'd2;
  localparam logic [3:0] BinMaxDigits = 4'd8;
  localparam logic [3:0] DecCountMax  = 4'd15;

endpackage

// ===== hdl/blp_parser.sv =====
`include "assert_macros.svh"

module blp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  blp_pkg::blp_item_t  item_i,
  output blp_pkg::blp_result_t result_o
);
  import blp_pkg::*;

  blp_state_t st_q, st_d;
  blp_state_t nx;
  blp_state_t body;

  logic [7:0]  fc;
  logic        c_dec;
  logic [3:0]  dec_d;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [12:0] dec_sum;
  logic [8:0]  dec_acc;
  logic [3:0]  dec_cnt;
  logic [8:0]  mag;

  // case fold and digit classification
  assign fc      = (item_i.character >= ChLowerA && item_i.character <= ChLowerZ) ?
                   item_i.character - CaseShift : item_i.character;
  assign c_dec   = (fc >= ChZero) && (fc <= ChNine);
  assign dec_d   = 4'(fc - ChZero);
  assign hex_ok  = c_dec || ((fc >= ChUpperA) && (fc <= ChUpperF));
  assign hex_d   = c_dec ? dec_d : 4'(fc - ChUpperA + 8'd10);

  // accumulate by ten, saturating
  assign dec_sum = {1'b0, st_q.accumulator, 3'b000} + {3'b000, st_q.accumulator, 1'b0}
                 + {9'd0, dec_d};
  assign dec_acc = (dec_sum > {4'd0, AccMax}) ? AccMax : dec_sum[8:0];
  assign dec_cnt = (st_q.digit_count < DecCountMax) ? st_q.digit_count + 4'd1
                                                    : st_q.digit_count;

  // first character of the literal body
  always_comb begin
    body = st_q;
    if (fc == ChZero) begin
      body.phase        = PH_ZERO;
      body.leading_zero = 1'b1;
      body.accumulator  = 9'd0;
      body.digit_count  = 4'd1;
      body.radix_form   = RF_DEC;
    end else if (c_dec) begin
      body.phase       = PH_DIGITS;
      body.radix_form  = RF_DEC;
      body.accumulator = {5'd0, dec_d};
      body.digit_count = 4'd1;
    end else begin
      body.phase         = PH_BAD;
      body.pending_error = STS_NUMBER;
    end
  end

  always_comb begin
    nx = st_q;
    if (item_i.has_char) begin
      unique case (st_q.phase)
        PH_BEGIN: begin
          if (fc == ChMinus) begin
            nx.is_negative = 1'b1;
            nx.phase       = PH_SFIRST;
          end else begin
            nx = body;
          end
        end
        PH_SFIRST: nx = body;
        PH_ZERO: begin
          if (fc == ChUpperX || fc == ChUpperB) begin
            nx.radix_form  = (fc == ChUpperX) ? RF_HEX : RF_BIN;
            nx.digit_count = 4'd0;
            nx.accumulator = 9'd0;
            nx.phase       = PH_DIGITS;
          end else if (c_dec) begin
            nx.phase       = PH_DIGITS;
            nx.accumulator = dec_acc;
            nx.digit_count = dec_cnt;
          end else begin
            nx.phase         = PH_BAD;
            nx.pending_error = STS_NUMBER;
          end
        end
        PH_DIGITS: begin
          if (st_q.radix_form == RF_HEX) begin
            if (!hex_ok || st_q.digit_count >= HexMaxDigits) begin
              nx.phase         = PH_BAD;
              nx.pending_error = STS_HEX;
            end else begin
              nx.accumulator = {st_q.accumulator[4:0], hex_d};
              nx.digit_count = st_q.digit_count + 4'd1;
            end
          end else if (st_q.radix_form == RF_BIN) begin
            if ((fc != ChZero && fc != ChOne) || st_q.digit_count >= BinMaxDigits) begin
              nx.phase         = PH_BAD;
              nx.pending_error = STS_BIN;
            end else begin
              nx.accumulator = {st_q.accumulator[7:0], fc == ChOne};
              nx.digit_count = st_q.digit_count + 4'd1;
            end
          end else if (c_dec) begin
            nx.accumulator = dec_acc;
            nx.digit_count = dec_cnt;
          end else begin
            nx.phase         = PH_BAD;
            nx.pending_error = STS_NUMBER;
          end
        end
        PH_BAD: nx = st_q;
        default: nx = st_q;
      endcase
    end
  end

  // end of literal: turn the updated state into a byte and a status
  assign mag = (nx.phase == PH_ZERO) ? 9'd0 : nx.accumulator;

  always_comb begin
    result_o.byte_value = 8'd0;
    result_o.status     = STS_OK;
    if (nx.phase == PH_BEGIN || nx.phase == PH_SFIRST) begin
      result_o.status = STS_NUMBER;
    end else if (nx.phase == PH_BAD) begin
      result_o.status = nx.pending_error;
    end else if (nx.phase == PH_DIGITS && nx.radix_form == RF_HEX &&
                 nx.digit_count == 4'd0) begin
      result_o.status = STS_HEX;
    end else if (nx.phase == PH_DIGITS && nx.radix_form == RF_BIN &&
                 nx.digit_count == 4'd0) begin
      result_o.status = STS_BIN;
    end else if (nx.phase == PH_DIGITS && nx.radix_form == RF_DEC && nx.leading_zero) begin
      result_o.status = STS_OCTAL;
    end else if (mag != 9'd0 && nx.is_negative) begin
      if (mag > NegMagMax) begin
        result_o.status = STS_SIGNED;
      end else begin
        result_o.byte_value = 8'(9'd256 - mag);
      end
    end else if (mag > ByteMax) begin
      result_o.status = STS_RANGE;
    end else begin
      result_o.byte_value = mag[7:0];
    end
  end

  always_comb begin
    st_d = st_q;
    if (step_i) begin
      st_d = item_i.last ? StateReset : nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else begin
      st_q <= st_d;
    end
  end

  `ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, step_i && item_i.last, st_q == StateReset)
  `ASSERT_IMPLY(a_bad_has_code, clk_i, rst_ni, st_q.phase == PH_BAD, st_q.pending_error != STS_OK)
  `ASSERT_NEXT(a_hold_without_step, clk_i, rst_ni, !step_i, $stable(st_q))

endmodule

// ===== hdl/byte_literal_parser.sv =====
// byte_literal_parser: streaming parser for an 8-bit numeric literal
// input channel: one character per request (character_i, has_char_i, last_i)
//   on in_valid_i; a request is taken on a clock edge with in_stall_o low
// accepted forms: optional minus, then 0x + 1..2 hex digits, 0b + 1..8 binary
//   digits, or decimal; letters compare case-insensitively
// output channel: one request per literal, issued for the request marked
//   last_i, carrying byte_value_o and status_o on out_valid_o
// order: a request is registered at the input and parsed from that register;
//   a final request's result is then registered and shown on out_valid_o
// throughput: one character per cycle while in_stall_o is low; the parse
//   state update (classify, accumulate by ten, finish checks) is combinational
// stall: a character that does not end a literal never waits for the output;
//   a final character waits in the input register while a result is held
//   by out_stall_i, and in_stall_o then rises
// reset: asynchronous, clears both registers' valid flags and the parse
//   state to the start of a literal; no clearing pass is needed
`include "assert_macros.svh"

module byte_literal_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           character_i,
  input  logic                 has_char_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           byte_value_o,
  output logic [2:0]           status_o
);
  import blp_pkg::*;

  // input register
  logic        s1_valid_q, s1_valid_d;
  blp_item_t   s1_item_q, s1_item_d;
  logic        s1_adv;
  logic        in_acc;

  // result register
  logic        out_valid_q, out_valid_d;
  blp_result_t res_q, res_d;
  blp_result_t res_comb;
  logic        res_load;

  // a non-final character only touches the parse state, so it moves on
  // regardless of the output side
  assign s1_adv   = s1_valid_q && (!s1_item_q.last || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign res_load = s1_adv && s1_item_q.last;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_item_d  = s1_item_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
      s1_item_d  = '{character: character_i, has_char: has_char_i, last: last_i};
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // parse state and finish logic
  blp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .result_o (res_comb)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      res_d       = res_comb;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
    res_q     <= res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign byte_value_o = res_q.byte_value;
  assign status_o     = res_q.status;

  `ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, res_load, out_valid_q)
  `ASSERT_IMPLY(a_error_zero_value, clk_i, rst_ni, out_valid_q && res_q.status != STS_OK, res_q.byte_value == 8'd0)
  `ASSERT_IMPLY(a_mid_never_blocks, clk_i, rst_ni, s1_valid_q && !s1_item_q.last, !in_stall_o)

endmodule
